// ===== rtl/core/i2c_mrt_pkg.sv =====
// ----------------------------------------------------------------------------
// i2c_mrt_pkg
// Shared types and constants for the I2C register transaction master.
// ----------------------------------------------------------------------------
package i2c_mrt_pkg;

    // Operation codes carried by the op field of an input beat.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_SPEAK = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_HALF_PERIOD = 3'd0;
    localparam logic [2:0] CFG_ACK_TIMEOUT = 3'd1;
    localparam logic [2:0] CFG_DEV_ADDR    = 3'd2;
    localparam logic [2:0] CFG_RESULT_REG  = 3'd3;
    localparam logic [2:0] CFG_SPEAK_REG   = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [15:0] HALF_RESET     = 16'd20;
    localparam logic [15:0] ACK_RESET      = 16'd80;
    localparam logic [6:0]  DEV_ADDR_RESET = 7'd52;
    localparam logic [7:0]  RESULT_RESET   = 8'd100;
    localparam logic [7:0]  SPEAK_RESET    = 8'd110;

    localparam logic [7:0] MSB_MASK = 8'h80;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [2:0] LAST_BYTE_STEP = 3'd3;

    // Bus sequencer phases: start condition, write bit, write ACK, read bit,
    // master NACK and stop condition.
    typedef enum logic [4:0] {
        P_IDLE = 5'd0,
        P_ST1, P_ST2, P_ST3,
        P_WB1, P_WB2, P_WB3,
        P_WA1, P_WA2, P_WAIT, P_WA4,
        P_RB1, P_RB2,
        P_NA1, P_NA2, P_NA3, P_NA4,
        P_SP1, P_SP2, P_SP3, P_SP4
    } t_phase;

    // One result beat.
    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic [2:0] fail_code;
    } t_result;

    // SCL level held in each phase.
    function automatic logic scl_of(input t_phase p);
        logic v;
        case (p)
            P_ST3, P_WB1, P_WB3, P_WA1, P_WA4, P_RB2,
            P_NA1, P_NA2, P_NA4, P_SP1, P_SP2: v = 1'b0;
            default:                           v = 1'b1;
        endcase
        return v;
    endfunction

    // SDA level held in each phase outside the write-bit phases.
    function automatic logic sda_of(input t_phase p);
        logic v;
        case (p)
            P_ST2, P_ST3, P_WB1, P_WB2, P_WB3, P_SP2, P_SP3: v = 1'b0;
            default:                                         v = 1'b1;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/i2c_master_register_transactions_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_master_register_transactions_unit
// I2C master that runs register read and speak write transactions, one bus
// tick per input beat.
// ----------------------------------------------------------------------------
// Every input beat is one timing tick of the bus sequencer and yields exactly
// one result beat with the SCL/SDA levels to drive, the busy and done flags,
// the last read byte and the fail code. The block takes one beat per clock:
// the whole sequencer step is one pass of logic from the state registers and
// the input ports into a two-entry result buffer, so a new beat is accepted in
// every cycle in which the buffer has a free entry, also while a finished
// result still waits to be taken. With op set to a read or a speak code
// while idle, a transaction starts and that same beat is the first tick of
// the START condition; op is ignored while a transaction runs. Each bus
// phase lasts half_period ticks, and an ACK is awaited with SCL high for at
// most ack_timeout ticks before the transaction is closed with STOP and a
// fail code. Configuration is written through a plain write port and
// should only change while the block is idle.
module i2c_master_register_transactions_unit #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_speak_cmd,
    input  logic [7:0]  i_speak_id,
    input  logic        i_sda_level,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_scl_release,
    output logic        o_sda_release,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [7:0]  o_read_byte,
    output logic [2:0]  o_fail_code
);
    import i2c_mrt_pkg::*;

    // The limit compare is done at the wider of the register and timer widths
    // so that registers above the timer range clamp to the timer maximum.
    localparam int CW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
    localparam logic [CW-1:0] TMAX = CW'((64'd1 << TIMER_WIDTH) - 64'd1);

    // Configuration registers.
    logic [15:0] r_half_period;
    logic [15:0] r_ack_timeout;
    logic [6:0]  r_dev_addr;
    logic [7:0]  r_result_reg;
    logic [7:0]  r_speak_reg;

    // Sequencer state.
    t_phase                 r_phase,      n_phase;
    logic [2:0]             r_byte_step,  n_byte_step;
    logic [3:0]             r_bit_count,  n_bit_count;
    logic [7:0]             r_shift_byte, n_shift_byte;
    logic [TIMER_WIDTH-1:0] r_delay_count, n_delay_count;
    logic [TIMER_WIDTH-1:0] r_ack_count,  n_ack_count;
    logic                   r_is_speak,   n_is_speak;
    logic [7:0]             r_held_cmd,   n_held_cmd;
    logic [7:0]             r_held_id,    n_held_id;
    logic [7:0]             r_last_read,  n_last_read;
    logic [2:0]             r_last_fail,  n_last_fail;

    // Two-entry result buffer.
    t_result    r_buf [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    t_result n_result;
    logic    in_beat;
    logic    out_beat;

    logic [CW-1:0]          half_ext;
    logic [CW-1:0]          ack_ext;
    logic [TIMER_WIDTH-1:0] half_limit;
    logic [TIMER_WIDTH-1:0] ack_limit;

    assign o_in_ready  = (r_count != 2'd2);
    assign o_out_valid = (r_count != 2'd0);
    assign in_beat     = i_in_valid && o_in_ready;
    assign out_beat    = o_out_valid && i_out_ready;

    // Phase and ACK limits, clamped to the timer range. A zero limit makes
    // every phase last one tick, the same as a limit of one.
    assign half_ext   = CW'(r_half_period);
    assign ack_ext    = CW'(r_ack_timeout);
    assign half_limit = (half_ext > TMAX) ? TMAX[TIMER_WIDTH-1:0] : half_ext[TIMER_WIDTH-1:0];
    assign ack_limit  = (ack_ext > TMAX) ? TMAX[TIMER_WIDTH-1:0] : ack_ext[TIMER_WIDTH-1:0];

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_RESET;
            r_ack_timeout <= ACK_RESET;
            r_dev_addr    <= DEV_ADDR_RESET;
            r_result_reg  <= RESULT_RESET;
            r_speak_reg   <= SPEAK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HALF_PERIOD: r_half_period <= i_cfg_data;
                CFG_ACK_TIMEOUT: r_ack_timeout <= i_cfg_data;
                CFG_DEV_ADDR:    r_dev_addr    <= i_cfg_data[6:0];
                CFG_RESULT_REG:  r_result_reg  <= i_cfg_data[7:0];
                CFG_SPEAK_REG:   r_speak_reg   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // One sequencer tick. A start is applied first, so the start beat already
    // runs the first tick of the START condition.
    always_comb begin
        logic                 busy;
        logic                 done;
        logic [TIMER_WIDTH:0] delay_inc;
        logic [TIMER_WIDTH:0] ack_inc;
        logic                 scl_lvl;
        logic                 sda_lvl;
        logic [7:0]           addr_byte;

        n_phase       = r_phase;
        n_byte_step   = r_byte_step;
        n_bit_count   = r_bit_count;
        n_shift_byte  = r_shift_byte;
        n_delay_count = r_delay_count;
        n_ack_count   = r_ack_count;
        n_is_speak    = r_is_speak;
        n_held_cmd    = r_held_cmd;
        n_held_id     = r_held_id;
        n_last_read   = r_last_read;
        n_last_fail   = r_last_fail;
        busy          = 1'b0;
        done          = 1'b0;
        scl_lvl       = 1'b1;
        sda_lvl       = 1'b1;
        addr_byte     = '0;

        if (r_phase == P_IDLE && (i_op == OP_READ || i_op == OP_SPEAK)) begin
            n_is_speak    = (i_op == OP_SPEAK);
            n_held_cmd    = i_speak_cmd;
            n_held_id     = i_speak_id;
            n_last_fail   = '0;
            n_byte_step   = '0;
            n_bit_count   = '0;
            n_shift_byte  = '0;
            n_delay_count = '0;
            n_ack_count   = '0;
            n_phase       = P_ST1;
        end

        delay_inc = {1'b0, n_delay_count} + 1'b1;
        ack_inc   = {1'b0, n_ack_count} + 1'b1;

        if (n_phase != P_IDLE) begin
            busy    = 1'b1;
            scl_lvl = scl_of(n_phase);
            if (n_phase == P_WB1 || n_phase == P_WB2 || n_phase == P_WB3) begin
                sda_lvl = |(n_shift_byte & MSB_MASK);
            end else begin
                sda_lvl = sda_of(n_phase);
            end

            if (n_phase == P_WAIT) begin
                // ACK window: a low SDA is the ACK, otherwise count toward
                // the timeout and fail when it is reached.
                if (!i_sda_level) begin
                    n_phase     = P_WA4;
                    n_ack_count = '0;
                end else if (ack_inc >= {1'b0, ack_limit}) begin
                    n_last_fail = n_byte_step + (n_is_speak ? 3'd4 : 3'd1);
                    if (!n_is_speak) begin
                        n_last_read = '0;
                    end
                    n_phase     = P_WA4;
                    n_ack_count = '0;
                end else begin
                    n_ack_count = ack_inc[TIMER_WIDTH-1:0];
                end
            end else if (delay_inc < {1'b0, half_limit}) begin
                n_delay_count = delay_inc[TIMER_WIDTH-1:0];
            end else begin
                n_delay_count = '0;
                case (n_phase)
                    P_ST1: n_phase = P_ST2;
                    P_ST2: n_phase = P_ST3;
                    P_ST3: begin
                        // Address byte: read form only after the repeated
                        // START of a register read.
                        addr_byte = {r_dev_addr, 1'b0};
                        if (n_byte_step == 3'd2 && !n_is_speak) begin
                            addr_byte[0] = 1'b1;
                        end
                        n_shift_byte = addr_byte;
                        n_bit_count  = '0;
                        n_phase      = P_WB1;
                    end
                    P_WB1: n_phase = P_WB2;
                    P_WB2: n_phase = P_WB3;
                    P_WB3: begin
                        n_shift_byte = {n_shift_byte[6:0], 1'b0};
                        n_bit_count  = n_bit_count + 1'b1;
                        n_phase      = (n_bit_count >= BITS_PER_BYTE) ? P_WA1 : P_WB1;
                    end
                    P_WA1: n_phase = P_WA2;
                    P_WA2: begin
                        n_ack_count = '0;
                        n_phase     = P_WAIT;
                    end
                    P_WA4: begin
                        if (n_last_fail != '0 || n_byte_step >= LAST_BYTE_STEP) begin
                            n_phase = P_SP1;
                        end else begin
                            n_byte_step = n_byte_step + 1'b1;
                            n_bit_count = '0;
                            if (n_is_speak) begin
                                n_phase = P_WB1;
                                case (n_byte_step)
                                    3'd1:    n_shift_byte = r_speak_reg;
                                    3'd2:    n_shift_byte = n_held_cmd;
                                    default: n_shift_byte = n_held_id;
                                endcase
                            end else begin
                                case (n_byte_step)
                                    3'd1: begin
                                        n_shift_byte = r_result_reg;
                                        n_phase      = P_WB1;
                                    end
                                    3'd2: n_phase = P_ST1;
                                    default: begin
                                        n_shift_byte = '0;
                                        n_phase      = P_RB1;
                                    end
                                endcase
                            end
                        end
                    end
                    P_RB1: begin
                        n_shift_byte = {n_shift_byte[6:0], i_sda_level};
                        n_phase      = P_RB2;
                    end
                    P_RB2: begin
                        n_bit_count = n_bit_count + 1'b1;
                        n_phase     = (n_bit_count >= BITS_PER_BYTE) ? P_NA1 : P_RB1;
                    end
                    P_NA1: n_phase = P_NA2;
                    P_NA2: n_phase = P_NA3;
                    P_NA3: n_phase = P_NA4;
                    P_NA4: n_phase = P_SP1;
                    P_SP1: n_phase = P_SP2;
                    P_SP2: n_phase = P_SP3;
                    P_SP3: n_phase = P_SP4;
                    P_SP4: begin
                        if (!n_is_speak && n_last_fail == '0) begin
                            n_last_read = n_shift_byte;
                        end
                        done    = 1'b1;
                        n_phase = P_IDLE;
                    end
                    default: n_phase = P_IDLE;
                endcase
            end
        end

        n_result.scl_release = scl_lvl;
        n_result.sda_release = sda_lvl;
        n_result.busy_res    = busy;
        n_result.done_res    = done;
        n_result.read_byte   = n_last_read;
        n_result.fail_code   = n_last_fail;
    end

    // Sequencer state advances once per accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= P_IDLE;
            r_byte_step   <= '0;
            r_bit_count   <= '0;
            r_shift_byte  <= '0;
            r_delay_count <= '0;
            r_ack_count   <= '0;
            r_is_speak    <= 1'b0;
            r_held_cmd    <= '0;
            r_held_id     <= '0;
            r_last_read   <= '0;
            r_last_fail   <= '0;
        end else if (in_beat) begin
            r_phase       <= n_phase;
            r_byte_step   <= n_byte_step;
            r_bit_count   <= n_bit_count;
            r_shift_byte  <= n_shift_byte;
            r_delay_count <= n_delay_count;
            r_ack_count   <= n_ack_count;
            r_is_speak    <= n_is_speak;
            r_held_cmd    <= n_held_cmd;
            r_held_id     <= n_held_id;
            r_last_read   <= n_last_read;
            r_last_fail   <= n_last_fail;
        end
    end

    // Result buffer: written on an input beat, drained on a result beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (in_beat) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (out_beat) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({in_beat, out_beat})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_buf[r_wr_ptr] <= n_result;
        end
    end

    assign o_scl_release = r_buf[r_rd_ptr].scl_release;
    assign o_sda_release = r_buf[r_rd_ptr].sda_release;
    assign o_busy_res    = r_buf[r_rd_ptr].busy_res;
    assign o_done_res    = r_buf[r_rd_ptr].done_res;
    assign o_read_byte   = r_buf[r_rd_ptr].read_byte;
    assign o_fail_code   = r_buf[r_rd_ptr].fail_code;

    // The result buffer never holds more than its two entries.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("result buffer count out of range");

    // A start beat taken while idle leaves the sequencer busy with no fail code.
    a_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && r_phase == P_IDLE && (i_op == OP_READ || i_op == OP_SPEAK))
        |=> (r_phase != P_IDLE && r_last_fail == '0))
        else $error("start beat did not begin a transaction");

    // A finishing tick is always reported as part of the transaction.
    a_done_is_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> o_busy_res)
        else $error("done reported outside a transaction");

    // Only a register read ever samples data bits from the slave.
    a_read_only_rb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == P_RB1 || r_phase == P_RB2) |-> !r_is_speak)
        else $error("speak write entered a read bit phase");

endmodule

// ===== tb/i2c_master_register_transactions_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_register_transactions_unit_tb
// Self-checking bench for the I2C register transaction master. Bus ticks are
// sent through the input channel. A cycle-free model of the sequencer
// predicts every result beat. Each beat taken from the result channel is
// checked in order against that prediction, under several register settings
// and several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module i2c_master_register_transactions_unit_tb;
    import i2c_mrt_pkg::*;

    // The op field has one spare code that the block must treat as a plain tick.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int MAX_REPORTS = 10;
    // Length of the forced receiver hold-off, long enough to fill the block.
    localparam int HOLD_CYCLES = 80;
    // Extra cycles watched after the last expected beat, well above the latency.
    localparam int SETTLE_CYCLES = 8;
    localparam int TIMEOUT_NS = 5_000_000;

    // One bus tick as it is offered to the block.
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] cmd;
        logic [7:0] id;
        logic       sda;
    } t_tick;

    // ------------------------------------------------------------------------
    // Block ports. Every input has a known value from time zero.
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_op = OP_TICK;
    logic [7:0]  i_speak_cmd = '0;
    logic [7:0]  i_speak_id = '0;
    logic        i_sda_level = 1'b1;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_scl_release;
    logic        o_sda_release;
    logic        o_busy_res;
    logic        o_done_res;
    logic [7:0]  o_read_byte;
    logic [2:0]  o_fail_code;

    i2c_master_register_transactions_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_speak_cmd   (i_speak_cmd),
        .i_speak_id    (i_speak_id),
        .i_sda_level   (i_sda_level),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_scl_release (o_scl_release),
        .o_sda_release (o_sda_release),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_read_byte   (o_read_byte),
        .o_fail_code   (o_fail_code)
    );

    // ------------------------------------------------------------------------
    // Bench state: pending ticks, predicted beats and run statistics.
    // ------------------------------------------------------------------------
    t_tick   tick_queue[$];
    t_result expected_beats[$];
    int      ticks_queued = 0;
    int      ticks_taken = 0;
    int      beats_checked = 0;
    int      err_count = 0;
    int      reads_done = 0;
    int      speaks_done = 0;
    int      nacks_seen = 0;
    logic    tick_taken = 1'b0;

    // Idle pattern of both channels, set per test phase by the stimulus.
    int      send_idle_pct = 0;
    int      stall_pct = 0;

    // A toggle of hold_trig asks the receiver process for a long hold-off.
    logic    hold_trig = 1'b0;
    logic    hold_seen = 1'b0;
    int      hold_left = 0;

    // ------------------------------------------------------------------------
    // Sequencer model: its own copy of the registers and of the bus state.
    // ------------------------------------------------------------------------
    logic [15:0] half_cfg = HALF_RESET;
    logic [15:0] ack_cfg = ACK_RESET;
    logic [6:0]  addr_cfg = DEV_ADDR_RESET;
    logic [7:0]  result_reg_cfg = RESULT_RESET;
    logic [7:0]  speak_reg_cfg = SPEAK_RESET;

    t_phase      bus_phase = P_IDLE;
    logic [2:0]  byte_no = '0;
    logic [3:0]  bit_no = '0;
    logic [7:0]  shift_reg = '0;
    int          delay_cnt = 0;
    int          ack_cnt = 0;
    logic        speak_mode = 1'b0;
    logic [7:0]  cmd_hold = '0;
    logic [7:0]  id_hold = '0;
    logic [7:0]  read_hold = '0;
    logic [2:0]  fail_hold = '0;

    // Levels {scl, sda} held in each phase. In the write-bit phases SDA comes
    // from the MSB of the shift register instead.
    function automatic logic [1:0] bus_levels(input t_phase p);
        logic [1:0] lv;
        case (p)
            P_ST2, P_SP3: lv = 2'b10;
            P_ST3, P_SP2: lv = 2'b00;
            P_WB1, P_WB3, P_WA1, P_WA4, P_RB2,
            P_NA1, P_NA2, P_NA4, P_SP1: lv = 2'b01;
            default: lv = 2'b11;
        endcase
        return lv;
    endfunction

    task automatic load_shift(input logic [7:0] b);
        shift_reg = b;
        bit_no = '0;
        bus_phase = P_WB1;
    endtask

    // Advances the model by one bus tick and returns the beat it produces.
    task automatic step_sequencer(input t_tick t, output t_result r);
        t_phase     p;
        logic [1:0] lv;
        logic       done;
        done = 1'b0;
        // A start is honored only from idle; the start tick is already the
        // first tick of the START condition.
        if (bus_phase == P_IDLE && (t.op == OP_READ || t.op == OP_SPEAK)) begin
            speak_mode = (t.op == OP_SPEAK);
            cmd_hold = t.cmd;
            id_hold = t.id;
            fail_hold = '0;
            byte_no = '0;
            bit_no = '0;
            shift_reg = '0;
            delay_cnt = 0;
            ack_cnt = 0;
            bus_phase = P_ST1;
        end
        p = bus_phase;
        lv = bus_levels(p);
        r.scl_release = lv[1];
        if (p == P_WB1 || p == P_WB2 || p == P_WB3) begin
            r.sda_release = shift_reg[7];
        end else begin
            r.sda_release = lv[0];
        end
        r.busy_res = (p != P_IDLE);

        if (p == P_WAIT) begin
            // The ACK is taken on any tick with SDA low; otherwise the tick
            // counts toward the timeout.
            if (!t.sda) begin
                bus_phase = P_WA4;
            end else if (ack_cnt + 1 >= int'(ack_cfg)) begin
                fail_hold = byte_no + (speak_mode ? 3'd4 : 3'd1);
                if (!speak_mode) begin
                    read_hold = '0;
                end
                bus_phase = P_WA4;
            end else begin
                ack_cnt++;
            end
            if (bus_phase == P_WA4) begin
                ack_cnt = 0;
            end
        end else if (p != P_IDLE && delay_cnt + 1 < int'(half_cfg)) begin
            delay_cnt++;
        end else if (p != P_IDLE) begin
            delay_cnt = 0;
            case (p)
                P_ST1: bus_phase = P_ST2;
                P_ST2: bus_phase = P_ST3;
                // The repeated START of a read is followed by the read address.
                P_ST3: load_shift({addr_cfg, byte_no == 3'd2 && !speak_mode});
                P_WB1: bus_phase = P_WB2;
                P_WB2: bus_phase = P_WB3;
                P_WB3: begin
                    shift_reg = shift_reg << 1;
                    bit_no++;
                    bus_phase = (bit_no >= BITS_PER_BYTE) ? P_WA1 : P_WB1;
                end
                P_WA1: bus_phase = P_WA2;
                P_WA2: begin
                    ack_cnt = 0;
                    bus_phase = P_WAIT;
                end
                P_WA4: begin
                    if (fail_hold != '0 || byte_no >= LAST_BYTE_STEP) begin
                        bus_phase = P_SP1;
                    end else begin
                        byte_no++;
                        if (speak_mode) begin
                            case (byte_no)
                                3'd1: load_shift(speak_reg_cfg);
                                3'd2: load_shift(cmd_hold);
                                default: load_shift(id_hold);
                            endcase
                        end else begin
                            case (byte_no)
                                3'd1: load_shift(result_reg_cfg);
                                3'd2: bus_phase = P_ST1;
                                default: begin
                                    shift_reg = '0;
                                    bit_no = '0;
                                    bus_phase = P_RB1;
                                end
                            endcase
                        end
                    end
                end
                // A read bit is sampled on the last tick of SCL high.
                P_RB1: begin
                    shift_reg = {shift_reg[6:0], t.sda};
                    bus_phase = P_RB2;
                end
                P_RB2: begin
                    bit_no++;
                    bus_phase = (bit_no >= BITS_PER_BYTE) ? P_NA1 : P_RB1;
                end
                P_NA1: bus_phase = P_NA2;
                P_NA2: bus_phase = P_NA3;
                P_NA3: bus_phase = P_NA4;
                P_NA4: bus_phase = P_SP1;
                P_SP1: bus_phase = P_SP2;
                P_SP2: bus_phase = P_SP3;
                P_SP3: bus_phase = P_SP4;
                default: begin
                    // End of STOP: the transaction is done.
                    if (!speak_mode && fail_hold == '0) begin
                        read_hold = shift_reg;
                    end
                    done = 1'b1;
                    bus_phase = P_IDLE;
                    if (speak_mode) begin
                        speaks_done++;
                    end else begin
                        reads_done++;
                    end
                    if (fail_hold != '0) begin
                        nacks_seen++;
                    end
                end
            endcase
        end
        r.done_res = done;
        r.read_byte = read_hold;
        r.fail_code = fail_hold;
    endtask

    // ------------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Scoreboard. At each rising edge a result beat that is taken is checked
    // against the oldest prediction first; then an input beat that is taken
    // runs through the model and its prediction is queued. Doing both in one
    // process keeps the order fixed.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : score
        t_result got;
        t_result want;
        t_tick   taken;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = {o_scl_release, o_sda_release, o_busy_res, o_done_res,
                       o_read_byte, o_fail_code};
                if (expected_beats.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $display("%0t: result beat with nothing expected", $realtime);
                    end
                end else begin
                    want = expected_beats.pop_front();
                    if (got.scl_release !== want.scl_release
                            || got.sda_release !== want.sda_release
                            || got.busy_res !== want.busy_res
                            || got.done_res !== want.done_res
                            || got.read_byte !== want.read_byte
                            || got.fail_code !== want.fail_code) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS) begin
                            $display("%0t: beat %0d expected scl=%b sda=%b busy=%b done=%b byte=%h fail=%0d",
                                     $realtime, beats_checked, want.scl_release,
                                     want.sda_release, want.busy_res, want.done_res,
                                     want.read_byte, want.fail_code);
                            $display("%0t: beat %0d actual   scl=%b sda=%b busy=%b done=%b byte=%h fail=%0d",
                                     $realtime, beats_checked, got.scl_release,
                                     got.sda_release, got.busy_res, got.done_res,
                                     got.read_byte, got.fail_code);
                        end
                    end
                    beats_checked++;
                end
            end
            if (i_in_valid && o_in_ready) begin
                taken = {i_op, i_speak_cmd, i_speak_id, i_sda_level};
                step_sequencer(taken, want);
                expected_beats.push_back(want);
                ticks_taken++;
                tick_taken <= 1'b1;
            end else begin
                tick_taken <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver. On the falling edge, once the current beat has been taken (or
    // none is offered), the next pending tick is offered unless the sender
    // idles this cycle. A beat on offer stays unchanged until it is taken.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive
        t_tick nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || tick_taken) begin
            if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = tick_queue.pop_front();
                i_op <= nxt.op;
                i_speak_cmd <= nxt.cmd;
                i_speak_id <= nxt.id;
                i_sda_level <= nxt.sda;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. Ready is random with the phase's stall rate, except during a
    // requested hold-off, which this process counts down itself.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_left <= 0;
            hold_seen <= hold_trig;
        end else if (hold_trig != hold_seen) begin
            hold_seen <= hold_trig;
            hold_left <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic tick(input logic [1:0] op, input logic [7:0] cmd,
                        input logic [7:0] id, input logic sda);
        tick_queue.push_back({op, cmd, id, sda});
        ticks_queued++;
    endtask

    // Waits until every tick has been taken and every predicted beat checked.
    task automatic wait_results();
        while (ticks_taken != ticks_queued || expected_beats.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Feeds plain ticks until the model is back in idle, so that registers
    // can be rewritten between transactions.
    task automatic settle_idle();
        wait_results();
        while (bus_phase != P_IDLE) begin
            for (int k = 0; k < 16; k++) begin
                tick(OP_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)),
                     1'($urandom_range(1)));
            end
            wait_results();
        end
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        // Nothing is in flight, so the model copy can change right away.
        case (idx)
            CFG_HALF_PERIOD: half_cfg = data;
            CFG_ACK_TIMEOUT: ack_cfg = data;
            CFG_DEV_ADDR:    addr_cfg = data[6:0];
            CFG_RESULT_REG:  result_reg_cfg = data[7:0];
            CFG_SPEAK_REG:   speak_reg_cfg = data[7:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [15:0] half, input logic [15:0] ack,
                               input logic [6:0] addr, input logic [7:0] res_reg,
                               input logic [7:0] spk_reg);
        write_reg(CFG_HALF_PERIOD, half);
        write_reg(CFG_ACK_TIMEOUT, ack);
        write_reg(CFG_DEV_ADDR, {9'd0, addr});
        write_reg(CFG_RESULT_REG, {8'd0, res_reg});
        write_reg(CFG_SPEAK_REG, {8'd0, spk_reg});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random ticks with the given share of SDA-low ticks. While the model is
    // idle most ticks start a transaction; while busy most are plain ticks,
    // with a few spare codes and starts that the block has to ignore. The
    // queue is kept short so that the model state is close to current.
    task automatic queue_ticks(input int n, input int low_pct);
        logic [1:0] op;
        int         pick;
        for (int k = 0; k < n; k++) begin
            while (tick_queue.size() >= 2) begin
                @(negedge i_clk);
            end
            pick = $urandom_range(99);
            if (bus_phase == P_IDLE) begin
                op = (pick < 40) ? OP_READ : (pick < 80) ? OP_SPEAK :
                     (pick < 90) ? OP_UNUSED : OP_TICK;
            end else begin
                op = (pick < 90) ? OP_TICK : (pick < 95) ? OP_UNUSED :
                     ($urandom_range(1) != 0) ? OP_READ : OP_SPEAK;
            end
            tick(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 ($urandom_range(99) >= low_pct));
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with short bus phases and the reset addresses: the
        // spare op code while idle, a speak write with extreme bytes, starts
        // and the spare code while busy, then a read that is always ACKed.
        load_config(16'd1, ACK_RESET, DEV_ADDR_RESET, RESULT_RESET, SPEAK_RESET);
        tick(OP_UNUSED, 8'hAA, 8'h55, 1'b1);
        tick(OP_TICK, 8'h00, 8'h00, 1'b0);
        tick(OP_SPEAK, 8'hFF, 8'h00, 1'b1);
        tick(OP_READ, 8'h00, 8'hFF, 1'b0);
        tick(OP_SPEAK, 8'h5A, 8'hA5, 1'b1);
        tick(OP_UNUSED, 8'h00, 8'h00, 1'b1);
        for (int k = 0; k < 6; k++) begin
            tick(OP_TICK, 8'h00, 8'h00, 1'(k));
        end
        settle_idle();
        tick(OP_READ, 8'h00, 8'h00, 1'b0);
        for (int k = 0; k < 12; k++) begin
            tick(OP_TICK, 8'hFF, 8'hFF, 1'b0);
        end
        settle_idle();

        // Highest address and register, short ACK timeout, no idling.
        load_config(16'd2, 16'd3, 7'h7F, 8'hFF, 8'h00);
        queue_ticks(150, 50);
        settle_idle();

        // Lowest address and register, ACK timeout of one tick so that a byte NACKs
        // unless SDA is low on its first ACK tick; the sender idles most of the time.
        send_idle_pct = 86;
        load_config(16'd1, 16'd1, 7'h00, 8'h00, 8'hFF);
        queue_ticks(150, 50);
        settle_idle();

        // Zero timing registers behave as one. The receiver stalls most of the
        // time, and once holds off long enough for the input to back up.
        send_idle_pct = 0;
        stall_pct = 86;
        load_config(16'd0, 16'd0, 7'($urandom_range(127)), 8'($urandom_range(255)),
                    8'($urandom_range(255)));
        queue_ticks(50, 50);
        hold_trig <= ~hold_trig;
        queue_ticks(100, 50);
        settle_idle();

        // Longest ACK timeout with both sides idling; halfway the sender waits
        // for every outstanding beat before going on.
        send_idle_pct = 32;
        stall_pct = 32;
        load_config(16'd3, 16'hFFFF, 7'($urandom_range(127)), 8'($urandom_range(255)),
                    8'($urandom_range(255)));
        queue_ticks(75, 60);
        wait_results();
        queue_ticks(75, 60);
        settle_idle();

        send_idle_pct = 0;
        stall_pct = 0;
        load_config(16'd1, 16'd2, 7'($urandom_range(127)), 8'($urandom_range(255)),
                    8'($urandom_range(255)));
        queue_ticks(100, 50);
        settle_idle();

        // Longest bus phases: only the first ticks of a transaction fit in the
        // run, which ends with the block still busy.
        load_config(16'hFFFF, 16'hFFFF, 7'($urandom_range(127)),
                    8'($urandom_range(255)), 8'($urandom_range(255)));
        queue_ticks(20, 50);

        wait_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (expected_beats.size() != 0) begin
            err_count += expected_beats.size();
            $display("%0d predicted beats never arrived", expected_beats.size());
        end

        $display("Checked %0d result beats from %0d ticks, %0d errors.",
                 beats_checked, ticks_taken, err_count);
        $display("Finished %0d reads and %0d speak writes, %0d of them ended by a NACK.",
                 reads_done, speaks_done, nacks_seen);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Hard limit on run time, far above the slowest correct run.
    initial begin
        #(TIMEOUT_NS);
        $display("Timeout: run did not finish in %0d ns", TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
